### hw/rtl/bdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared constants and types for the cubic Bezier (de Casteljau) evaluator.
// ----------------------------------------------------------------------------
package bdc_pkg;

  localparam int NUM_POINTS = 4;
  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;

  localparam int NUM_AXES   = 2;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int NUM_LEVELS = NUM_POINTS - 1;

  // curve parameter: unsigned Q0.16 plus one integer bit for 1.0
  localparam int T_FRAC = 16;
  localparam int T_W    = T_FRAC + 1;

  // interpolated point: unsigned, stays inside the control hull
  localparam int POINT_W = COORD_BITS + FRAC_BITS;
  // signed difference between two points
  localparam int DIFF_W  = POINT_W + 1;
  // signed product of t and a difference
  localparam int PROD_W  = T_W + 1 + DIFF_W;

  typedef logic [COORD_BITS-1:0] bdc_coord_t;
  typedef logic [T_W-1:0]        bdc_param_t;

  typedef logic [NUM_AXES-1:0][NUM_POINTS-1:0][COORD_BITS-1:0] bdc_ctrl_t;
  typedef logic [NUM_AXES-1:0][NUM_POINTS-1:0][POINT_W-1:0]    bdc_pts_t;

  // payload carried between pipeline levels
  typedef struct packed {
    bdc_param_t t;
    bdc_pts_t   pts;
  } bdc_stage_t;

endpackage

### hw/rtl/bdc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_in_if
// Input channel: one curve parameter per item.
// ----------------------------------------------------------------------------
interface bdc_in_if;
  logic              valid;
  logic              ready;
  bdc_pkg::bdc_param_t curve_param;

  modport source (output valid, output curve_param, input ready);
  modport sink   (input valid, input curve_param, output ready);
endinterface

### hw/rtl/bdc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_out_if
// Output channel: one curve point per item.
// ----------------------------------------------------------------------------
interface bdc_out_if;
  logic              valid;
  logic              ready;
  bdc_pkg::bdc_coord_t point_x;
  bdc_pkg::bdc_coord_t point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

### hw/rtl/bdc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_cfg_regs
// Control point registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bdc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bdc_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  bdc_pkg::bdc_coord_t           cfg_data_i,
  output bdc_pkg::bdc_ctrl_t            ctrl_o
);

  bdc_pkg::bdc_coord_t regs_q [bdc_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < bdc_pkg::NUM_REGS; r++) begin
        regs_q[r] <= '0;
      end
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // register 2*i+axis holds coordinate axis of control point i
  always_comb begin
    for (int i = 0; i < bdc_pkg::NUM_POINTS; i++) begin
      for (int a = 0; a < bdc_pkg::NUM_AXES; a++) begin
        ctrl_o[a][i] = regs_q[2 * i + a];
      end
    end
  end

endmodule

### hw/rtl/bdc_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_level
// One level of the de Casteljau triangle on both axes: a multiply stage
// followed by an add stage. Point i becomes lerp(p[i], p[i+1], t); the last
// point passes through.
// ----------------------------------------------------------------------------
module bdc_level (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bdc_pkg::bdc_stage_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bdc_pkg::bdc_stage_t out_data_o
);

  localparam int NL = bdc_pkg::NUM_POINTS - 1;

  typedef logic signed [bdc_pkg::DIFF_W-1:0] step_t;

  // multiply stage
  logic                mul_valid_q;
  logic                mul_ready;
  bdc_pkg::bdc_stage_t mul_data_q;
  step_t               step_d [bdc_pkg::NUM_AXES][NL];
  step_t               step_q [bdc_pkg::NUM_AXES][NL];

  // add stage
  logic                add_valid_q;
  logic                add_ready;
  bdc_pkg::bdc_stage_t add_data_d;
  bdc_pkg::bdc_stage_t add_data_q;

  assign add_ready  = !add_valid_q || out_ready_i;
  assign mul_ready  = !mul_valid_q || add_ready;
  assign in_ready_o = mul_ready;

  // floor(t * (q - p) / 2^16): the part-select of the signed product is the
  // arithmetic shift, which rounds toward negative infinity
  always_comb begin
    logic signed [bdc_pkg::T_W:0]      ts;
    logic signed [bdc_pkg::DIFF_W-1:0] diff;
    logic signed [bdc_pkg::PROD_W-1:0] prod;
    ts = $signed({1'b0, in_data_i.t});
    for (int a = 0; a < bdc_pkg::NUM_AXES; a++) begin
      for (int i = 0; i < NL; i++) begin
        diff = $signed({1'b0, in_data_i.pts[a][i+1]}) - $signed({1'b0, in_data_i.pts[a][i]});
        prod = ts * diff;
        step_d[a][i] = $signed(prod[bdc_pkg::T_FRAC +: bdc_pkg::DIFF_W]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (mul_ready) begin
      mul_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && in_valid_i) begin
      mul_data_q <= in_data_i;
      step_q     <= step_d;
    end
  end

  // results stay inside the hull, so the sum fits POINT_W unsigned bits
  always_comb begin
    logic [bdc_pkg::DIFF_W-1:0] sum;
    add_data_d = mul_data_q;
    for (int a = 0; a < bdc_pkg::NUM_AXES; a++) begin
      for (int i = 0; i < NL; i++) begin
        sum = {1'b0, mul_data_q.pts[a][i]} + step_q[a][i];
        add_data_d.pts[a][i] = sum[bdc_pkg::POINT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_valid_q <= 1'b0;
    end else if (add_ready) begin
      add_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_ready && mul_valid_q) begin
      add_data_q <= add_data_d;
    end
  end

  assign out_valid_o = add_valid_q;
  assign out_data_o  = add_data_q;

endmodule

### hw/rtl/bezier_de_casteljau_eval_top.sv
`timescale 1ns / 1ps
// Pipeline: the input register loads at the accept, then a multiply and an add
//   register per triangle level, then the output register.
// Throughput: one item per cycle; every stage carries its own valid bit and
//   a stall holds the stages that cannot advance.
// Reset: clears all valid bits and the control points to zero.
// ----------------------------------------------------------------------------
// bezier_de_casteljau_eval_top
// Cubic Bezier point evaluator, de Casteljau interpolation in fixed point.
// ----------------------------------------------------------------------------
module bezier_de_casteljau_eval_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bdc_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  bdc_pkg::bdc_coord_t          cfg_data_i,
  bdc_in_if.sink                       in_i,
  bdc_out_if.source                    out_o
);

  localparam int NLV = bdc_pkg::NUM_LEVELS;

  bdc_pkg::bdc_ctrl_t  ctrl;

  logic                lvl_valid [NLV+1];
  logic                lvl_ready [NLV+1];
  bdc_pkg::bdc_stage_t lvl_data  [NLV+1];

  logic                in_valid_q;
  bdc_pkg::bdc_stage_t in_data_d;
  bdc_pkg::bdc_stage_t in_data_q;

  logic                out_valid_q;
  logic                out_ready;
  bdc_pkg::bdc_coord_t point_x_q;
  bdc_pkg::bdc_coord_t point_y_q;

  bdc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_o     (ctrl)
  );

  // input register: saturate t to 1.0, scale control points to fixed point
  always_comb begin
    if (in_i.curve_param[bdc_pkg::T_W-1]) begin
      in_data_d.t = bdc_pkg::bdc_param_t'(1) << bdc_pkg::T_FRAC;
    end else begin
      in_data_d.t = in_i.curve_param;
    end
    for (int a = 0; a < bdc_pkg::NUM_AXES; a++) begin
      for (int i = 0; i < bdc_pkg::NUM_POINTS; i++) begin
        in_data_d.pts[a][i] = {ctrl[a][i], {bdc_pkg::FRAC_BITS{1'b0}}};
      end
    end
  end

  assign in_i.ready = !in_valid_q || lvl_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_data_q <= in_data_d;
    end
  end

  assign lvl_valid[0] = in_valid_q;
  assign lvl_data[0]  = in_data_q;

  for (genvar k = 0; k < NLV; k++) begin : g_level
    bdc_level u_level (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (lvl_valid[k]),
      .in_ready_o  (lvl_ready[k]),
      .in_data_i   (lvl_data[k]),
      .out_valid_o (lvl_valid[k+1]),
      .out_ready_i (lvl_ready[k+1]),
      .out_data_o  (lvl_data[k+1])
    );
  end

  // output register: integer part of the first point after the last level
  assign out_ready      = !out_valid_q || out_o.ready;
  assign lvl_ready[NLV] = out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= lvl_valid[NLV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && lvl_valid[NLV]) begin
      point_x_q <= lvl_data[NLV].pts[0][0][bdc_pkg::POINT_W-1 -: bdc_pkg::COORD_BITS];
      point_y_q <= lvl_data[NLV].pts[1][0][bdc_pkg::POINT_W-1 -: bdc_pkg::COORD_BITS];
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.point_x = point_x_q;
  assign out_o.point_y = point_y_q;

endmodule

### tb/bdc_point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_point_checker
// Watches the control-point writes and both channels of the Bezier evaluator,
// computes the curve point for every accepted parameter and compares each
// returned point, in order, against it.
// ----------------------------------------------------------------------------
module bdc_point_checker
  import bdc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  bdc_coord_t           cfg_data_i,
  bdc_in_if                    in_i,
  bdc_out_if                   out_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam longint T_ONE = longint'(1) << T_FRAC;

  typedef struct packed {
    bdc_coord_t x;
    bdc_coord_t y;
  } curve_point_t;

  // register index is 2 * point + axis
  bdc_coord_t   ctrl_copy [NUM_REGS];
  curve_point_t pending_points [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  // One de Casteljau triangle on one axis, floor on every lerp.
  function automatic bdc_coord_t lerp_axis(input int axis, input bdc_param_t t_raw);
    longint pts [NUM_POINTS];
    longint t;
    t = (longint'(t_raw) > T_ONE) ? T_ONE : longint'(t_raw);
    for (int k = 0; k < NUM_POINTS; k++)
      pts[k] = longint'(ctrl_copy[2*k + axis]) <<< FRAC_BITS;
    for (int lvl = 1; lvl < NUM_POINTS; lvl++)
      for (int k = 0; k < NUM_POINTS - lvl; k++)
        pts[k] = pts[k] + ((t * (pts[k+1] - pts[k])) >>> T_FRAC);
    if (pts[0] < 0) pts[0] = 0;
    return bdc_coord_t'(pts[0] >>> FRAC_BITS);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    curve_point_t want;
    if (!rst_ni) begin
      foreach (ctrl_copy[i]) ctrl_copy[i] = '0;
      pending_points.delete();
    end else begin
      if (cfg_we_i && cfg_idx_i < NUM_REGS) ctrl_copy[cfg_idx_i] = cfg_data_i;
      if (in_i.valid && in_i.ready) begin
        want.x = lerp_axis(0, in_i.curve_param);
        want.y = lerp_axis(1, in_i.curve_param);
        pending_points.push_back(want);
      end
      if (out_i.valid && out_i.ready) begin
        if (pending_points.size() == 0) begin
          report_mismatch($sformatf("point (%0d,%0d) with none expected",
                                    out_i.point_x, out_i.point_y));
        end else begin
          want = pending_points.pop_front();
          if (out_i.point_x !== want.x)
            report_mismatch($sformatf("point_x %0d, expected %0d", out_i.point_x, want.x));
          if (out_i.point_y !== want.y)
            report_mismatch($sformatf("point_y %0d, expected %0d", out_i.point_y, want.y));
        end
      end
    end
    pending_o = pending_points.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the Bezier evaluator: programs several control-point sets, sends
// corner and random curve parameters with random gaps and output stalls,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  import bdc_pkg::*;

  localparam int ITEMS_PER_SET = 230;
  localparam int NUM_SETS      = 8;
  localparam int DRAIN_CYCLES  = 32;
  localparam int STALL_LIMIT   = 2000;
  localparam int AXIS_X        = 0;
  localparam int AXIS_Y        = 1;
  localparam bdc_coord_t COORD_MAX = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  bdc_coord_t           cfg_data;
  int                   fail_count;
  int                   pending;

  bdc_in_if  in_ch ();
  bdc_out_if out_ch ();

  bezier_de_casteljau_eval_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  bdc_point_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  bdc_coord_t ctrl_val [2][NUM_POINTS];
  int         gap_pct;
  int         stall_pct;
  bit         quiet;
  int         stall_left;

  // output side back-pressure
  always @(negedge clk_i) begin
    if (quiet) begin
      stall_left = 0;
      out_ch.ready <= 1'b1;
    end else begin
      if (stall_left == 0 && $urandom_range(99) < stall_pct)
        stall_left = $urandom_range(18, 1);
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic int pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 4;
      default: return 15;
    endcase
  endfunction

  function automatic bdc_param_t rand_param();
    case ($urandom_range(9))
      0:       return bdc_param_t'($urandom_range(131071));
      1:       return bdc_param_t'($urandom_range(65536, 65530));
      2:       return bdc_param_t'($urandom_range(5));
      default: return bdc_param_t'($urandom_range(65536));
    endcase
  endfunction

  function automatic bdc_coord_t rand_coord();
    case ($urandom_range(3))
      0:       return '0;
      1:       return COORD_MAX;
      default: return bdc_coord_t'($urandom_range(1023));
    endcase
  endfunction

  task automatic send_param(input bdc_param_t t);
    if ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.curve_param <= t;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drop valid and wait until every point is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic load_ctrl();
    for (int k = 0; k < NUM_POINTS; k++) begin
      for (int a = 0; a < 2; a++) begin
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_IDX_W'(2*k + a);
        cfg_data <= ctrl_val[a][k];
        @(posedge clk_i);
        @(negedge clk_i);
      end
    end
    cfg_we <= 1'b0;
  endtask

  bdc_param_t corner_params [12] = '{
    17'h00000, 17'h00001, 17'h00002, 17'h08000, 17'h0AAAA, 17'h0FFFE,
    17'h0FFFF, 17'h10000, 17'h10001, 17'h15555, 17'h1FFFF, 17'h0C000
  };

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.curve_param = '0;
    out_ch.ready      = 1'b0;
    quiet             = 1'b0;
    stall_left        = 0;
    gap_pct           = 4;
    stall_pct         = 4;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // all control points still at zero after reset
    foreach (corner_params[i]) send_param(corner_params[i]);
    drain();

    // zigzag hull: largest swings, negative differences on every level
    for (int k = 0; k < NUM_POINTS; k++) begin
      ctrl_val[AXIS_X][k] = (k % 2) ? COORD_MAX : '0;
      ctrl_val[AXIS_Y][k] = (k % 2) ? '0 : COORD_MAX;
    end
    load_ctrl();
    foreach (corner_params[i]) send_param(corner_params[i]);
    drain();

    for (int s = 0; s < NUM_SETS; s++) begin
      for (int k = 0; k < NUM_POINTS; k++) begin
        case (s)
          0: begin
            ctrl_val[AXIS_X][k] = COORD_MAX;
            ctrl_val[AXIS_Y][k] = COORD_MAX;
          end
          1: begin
            ctrl_val[AXIS_X][k] = (k % 2) ? '0 : COORD_MAX;
            ctrl_val[AXIS_Y][k] = (k % 2) ? COORD_MAX : '0;
          end
          default: begin
            ctrl_val[AXIS_X][k] = rand_coord();
            ctrl_val[AXIS_Y][k] = rand_coord();
          end
        endcase
      end
      load_ctrl();
      if (s == NUM_SETS - 1) begin
        quiet     = 1'b1;
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
      end
      repeat (ITEMS_PER_SET) send_param(rand_param());
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### files.f
hw/rtl/bdc_pkg.sv
hw/rtl/bdc_in_if.sv
hw/rtl/bdc_out_if.sv
hw/rtl/bdc_cfg_regs.sv
hw/rtl/bdc_level.sv
hw/rtl/bezier_de_casteljau_eval_top.sv
tb/bdc_point_checker.sv
tb/testbench.sv
